/* rtl/core/radix_integer_to_text_macros.svh */
// assertion macros for the radix integer to text block
// no dependencies; included by the rtl files that carry assertions
`ifndef RADIX_INTEGER_TO_TEXT_MACROS_SVH
`define RADIX_INTEGER_TO_TEXT_MACROS_SVH

`ifndef ASSERT_OFF

// implication checked every clock, muted while reset is high
`define RIT_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// one-hot check, muted while reset is high
`define RIT_ASSERT_ONEHOT(name, clk, rst, sig, msg) \
  name: assert property (@(posedge clk) disable iff (rst) $onehot(sig)) else $error(msg);

`else

`define RIT_ASSERT(name, clk, rst, prop, msg)
`define RIT_ASSERT_ONEHOT(name, clk, rst, sig, msg)

`endif

`endif

/* rtl/core/rit_pkg.sv */
// shared types, constants and character lookup for radix integer to text
// no dependencies
`default_nettype none

package rit_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int FIELD_WIDTH = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
  localparam int DIGIT_DEPTH = VALUE_WIDTH;
  localparam int ADDR_W      = $clog2(DIGIT_DEPTH);
  localparam int CNT_W       = $clog2(DIGIT_DEPTH + 1);
  localparam int STEP_W      = $clog2(VALUE_WIDTH);
  localparam int DIGIT_W     = 4;
  localparam int BASE_W      = 5;
  localparam int CHAR_W      = 7;

  localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
  localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(16);

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [VALUE_WIDTH-1:0] value_t;

  localparam char_t CHAR_MINUS = 7'h2d;
  localparam char_t CHAR_ERROR = 7'h00;

  localparam char_t LOWER_DIGITS [16] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
  };
  localparam char_t UPPER_DIGITS [16] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
  };

  // sequencer states
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_START = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_SIGN  = 7'b0001000,
    S_READ  = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_ERR   = 7'b1000000
  } state_t;

  // divider result, valid in the cycle that done is high
  typedef struct packed {
    logic               done;
    value_t             quotient;
    logic [DIGIT_W-1:0] remainder;
  } div_status_t;

  function automatic char_t digit_char(input logic [DIGIT_W-1:0] digit, input logic lower);
    char_t ch;
    if (lower) begin
      ch = LOWER_DIGITS[digit];
    end else begin
      ch = UPPER_DIGITS[digit];
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/rit_channels.sv */
// valid/ready channel interfaces for the number input and the text output
// depends on rit_pkg
`default_nettype none

interface rit_number_if;
  logic                    valid;
  logic                    ready;
  logic [31:0]             value_bits;
  logic [rit_pkg::BASE_W-1:0] base;
  logic                    unsigned_mode;
  logic                    lowercase;

  modport source (output valid, value_bits, base, unsigned_mode, lowercase, input ready);
  modport sink   (input valid, value_bits, base, unsigned_mode, lowercase, output ready);
endinterface

interface rit_text_if;
  logic                 valid;
  logic                 ready;
  logic [rit_pkg::CHAR_W-1:0] char_code;
  logic                 last_char;
  logic                 bad_base;

  modport source (output valid, char_code, last_char, bad_base, input ready);
  modport sink   (input valid, char_code, last_char, bad_base, output ready);
endinterface

`default_nettype wire

/* rtl/core/rit_ram.sv */
// generic single write port ram with registered, enabled read
// no dependencies
`default_nettype none

module rit_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/rit_divider.sv */
// bit-serial restoring divider: value by a 5 bit base, one quotient bit per cycle
// depends on rit_pkg
`default_nettype none

module rit_divider (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire rit_pkg::value_t              dividend,
  input  wire logic [rit_pkg::BASE_W-1:0]   base,
  output      rit_pkg::div_status_t         status
);

  logic                                busy;
  logic                                done;
  logic [rit_pkg::STEP_W-1:0]          step;
  rit_pkg::value_t                     quo;
  logic [rit_pkg::DIGIT_W-1:0]         rem;
  logic [rit_pkg::BASE_W-1:0]          partial;
  logic                                fits;
  logic [rit_pkg::BASE_W-1:0]          diff;

  // shift next dividend bit into the partial remainder and trial-subtract
  assign partial = {rem, quo[rit_pkg::VALUE_WIDTH-1]};
  assign fits    = partial >= base;
  assign diff    = partial - base;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend;
      rem  <= '0;
      step <= rit_pkg::STEP_W'(rit_pkg::VALUE_WIDTH - 1);
    end else if (busy) begin
      quo  <= {quo[rit_pkg::VALUE_WIDTH-2:0], fits};
      rem  <= fits ? diff[rit_pkg::DIGIT_W-1:0] : partial[rit_pkg::DIGIT_W-1:0];
      step <= step - 1'b1;
    end
  end

  assign status.done      = done;
  assign status.quotient  = quo;
  assign status.remainder = rem;

endmodule

`default_nettype wire

/* rtl/core/radix_integer_to_text.sv */
// top level: sequencer, digit store and output word register
// depends on rit_pkg, rit_channels, rit_ram, rit_divider and the assertion macros
`default_nettype none
`include "radix_integer_to_text_macros.svh"

// Converts one integer word into ASCII text in a base from 2 to 16, most
// significant character first, with last_char set on the final character.
// In signed mode a negative value is sent as '-' followed by its magnitude;
// zero gives "0"; digits above 9 are letters in the case chosen by lowercase.
// A base outside 2..16 gives a single word with char_code 0, last_char 1 and
// bad_base 1. Only the low VALUE_WIDTH bits of value_bits are used. The
// block takes one number at a time: number.ready is high only while idle.
// Each digit comes from one pass of a shared bit-serial divider, which is
// restarted for every digit. The digits are then sent from the digit store,
// each character as a registered read of the store followed by the load of
// the output register, with a sign character loaded first when negative. The
// output register lets the next number be accepted while the final character
// still waits to be taken.
module radix_integer_to_text (
  input wire logic  clk,
  input wire logic  rst,
  rit_number_if.sink  number,
  rit_text_if.source  text
);

  localparam logic [rit_pkg::CNT_W-1:0] CNT_ZERO = '0;
  localparam logic [rit_pkg::CNT_W-1:0] CNT_FULL = rit_pkg::CNT_W'(rit_pkg::DIGIT_DEPTH);

  rit_pkg::state_t                 state, state_next;
  logic [rit_pkg::CNT_W-1:0]       count;
  logic [rit_pkg::CNT_W-1:0]       cnt_dec;
  rit_pkg::value_t                 remaining;
  logic                            negative;
  logic                            lowercase_q;
  logic [rit_pkg::BASE_W-1:0]      base_q;

  // output word register
  logic                            out_valid;
  rit_pkg::char_t                  out_char;
  logic                            out_last;
  logic                            out_bad;
  logic                            out_free;

  // load request for the output register
  logic                            load;
  rit_pkg::char_t                  load_char;
  logic                            load_last;
  logic                            load_bad;

  // input decode
  logic [rit_pkg::FIELD_WIDTH-1:0] value_ext;
  rit_pkg::value_t                 value_in;
  logic                            bad_in;
  logic                            neg_in;

  rit_pkg::div_status_t            div;
  logic                            ram_we;
  logic                            ram_re;
  logic [rit_pkg::DIGIT_W-1:0]     ram_rdata;

  assign value_ext = rit_pkg::FIELD_WIDTH'(number.value_bits);
  assign value_in  = value_ext[rit_pkg::VALUE_WIDTH-1:0];
  assign bad_in    = (number.base < rit_pkg::BASE_MIN) || (number.base > rit_pkg::BASE_MAX);
  assign neg_in    = !number.unsigned_mode && value_in[rit_pkg::VALUE_WIDTH-1];

  assign cnt_dec   = count - 1'b1;
  assign out_free  = !out_valid || text.ready;

  assign number.ready = (state == rit_pkg::S_IDLE);

  // digit store, least significant digit at address 0
  assign ram_we = (state == rit_pkg::S_DIV) && div.done;
  assign ram_re = (state == rit_pkg::S_READ);

  rit_ram #(
    .WIDTH (rit_pkg::DIGIT_W),
    .DEPTH (rit_pkg::DIGIT_DEPTH)
  ) u_digit_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[rit_pkg::ADDR_W-1:0]),
    .wdata (div.remainder),
    .re    (ram_re),
    .raddr (cnt_dec[rit_pkg::ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // shared divider, restarted once per digit
  rit_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (state == rit_pkg::S_START),
    .dividend (remaining),
    .base     (base_q),
    .status   (div)
  );

  // sequencer
  always_comb begin
    state_next = state;
    load       = 1'b0;
    load_char  = rit_pkg::CHAR_ERROR;
    load_last  = 1'b0;
    load_bad   = 1'b0;
    unique case (state)
      rit_pkg::S_IDLE: begin
        if (number.valid) begin
          state_next = bad_in ? rit_pkg::S_ERR : rit_pkg::S_START;
        end
      end
      rit_pkg::S_START: begin
        state_next = rit_pkg::S_DIV;
      end
      rit_pkg::S_DIV: begin
        if (div.done) begin
          if (div.quotient != '0) begin
            state_next = rit_pkg::S_START;
          end else if (negative) begin
            state_next = rit_pkg::S_SIGN;
          end else begin
            state_next = rit_pkg::S_READ;
          end
        end
      end
      rit_pkg::S_SIGN: begin
        if (out_free) begin
          load       = 1'b1;
          load_char  = rit_pkg::CHAR_MINUS;
          state_next = rit_pkg::S_READ;
        end
      end
      rit_pkg::S_READ: begin
        state_next = rit_pkg::S_EMIT;
      end
      rit_pkg::S_EMIT: begin
        if (out_free) begin
          load       = 1'b1;
          load_char  = rit_pkg::digit_char(ram_rdata, lowercase_q);
          load_last  = (count == CNT_ZERO);
          state_next = (count == CNT_ZERO) ? rit_pkg::S_IDLE : rit_pkg::S_READ;
        end
      end
      rit_pkg::S_ERR: begin
        if (out_free) begin
          load       = 1'b1;
          load_char  = rit_pkg::CHAR_ERROR;
          load_last  = 1'b1;
          load_bad   = 1'b1;
          state_next = rit_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rit_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rit_pkg::S_IDLE;
      count     <= '0;
      remaining <= '0;
      negative  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (text.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        rit_pkg::S_IDLE: begin
          if (number.valid && !bad_in) begin
            negative  <= neg_in;
            remaining <= neg_in ? (rit_pkg::value_t'(0) - value_in) : value_in;
            count     <= '0;
          end
        end
        rit_pkg::S_DIV: begin
          if (div.done) begin
            remaining <= div.quotient;
            count     <= count + 1'b1;
          end
        end
        rit_pkg::S_READ: begin
          count <= cnt_dec;
        end
        default: begin
        end
      endcase
    end
  end

  // per-number settings, no reset needed
  always_ff @(posedge clk) begin
    if (number.valid && number.ready) begin
      base_q      <= number.base;
      lowercase_q <= number.lowercase;
    end
    if (load) begin
      out_char <= load_char;
      out_last <= load_last;
      out_bad  <= load_bad;
    end
  end

  assign text.valid     = out_valid;
  assign text.char_code = out_char;
  assign text.last_char = out_last;
  assign text.bad_base  = out_bad;

  `RIT_ASSERT_ONEHOT(a_state_onehot, clk, rst, state, "sequencer state not one-hot")
  `RIT_ASSERT(a_store_in_range, clk, rst, ram_we |-> (count < CNT_FULL), "digit store overrun")
  `RIT_ASSERT(a_bad_word_form, clk, rst,
    (text.valid && text.bad_base) |-> (text.last_char && (text.char_code == rit_pkg::CHAR_ERROR)),
    "malformed error word")
  `RIT_ASSERT(a_last_ends_item, clk, rst, (load && load_last) |=> (state == rit_pkg::S_IDLE),
    "last word did not end the conversion")
  `RIT_ASSERT(a_no_overwrite, clk, rst, load |-> out_free, "output word overwritten while pending")

endmodule

`default_nettype wire
